>>> rtl/modular_arithmetic_unit_defines.svh
// Assertion macros for the modular arithmetic unit checker.
`ifndef MODULAR_ARITHMETIC_UNIT_DEFINES_SVH
`define MODULAR_ARITHMETIC_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MAU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mau_pkg.sv
// Shared types and constants for the modular arithmetic unit.
`default_nettype none

package mau_pkg;

  localparam int unsigned DATA_W = 30;
  localparam int unsigned EXP_W  = 63;

  localparam logic [DATA_W-1:0] MODULUS = 30'd1000000007;
  // Fermat inverse exponent, MODULUS - 2.
  localparam logic [DATA_W-1:0] INV_EXP = 30'd1000000005;
  // Barrett constant floor(2^60 / MODULUS).
  localparam logic [30:0] BARRETT_MU = 31'd1152921496;
  localparam logic [31:0] MODULUS_X2 = 32'd2000000014;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_POW = 3'd3,
    OP_DIV = 3'd4
  } op_t;

  // Control that travels alongside an operand pair through the multiplier.
  typedef struct packed {
    logic valid;
    logic acc_dst;
  } mm_ctl_t;

endpackage

`default_nettype wire

>>> rtl/mau_modmul.sv
// Four-stage pipelined modular multiplier using Barrett reduction.
`default_nettype none

module mau_modmul
  import mau_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mm_ctl_t           req_ctl,
  input  wire logic [DATA_W-1:0] req_x,
  input  wire logic [DATA_W-1:0] req_y,
  output mm_ctl_t                rsp_ctl,
  output logic      [DATA_W-1:0] rsp_r
);

  mm_ctl_t ctl1_r, ctl2_r, ctl3_r, ctl4_r;
  logic [59:0]       prod_r;
  logic [61:0]       q2_r;
  logic [31:0]       p2_r, p3_r;
  logic [31:0]       t_r;
  logic [DATA_W-1:0] res_r;

  logic [30:0] q1;
  logic [30:0] q3;
  logic [31:0] diff;
  logic [31:0] diff_m1;
  logic [31:0] diff_m2;
  logic [DATA_W-1:0] res_nxt;

  assign q1 = prod_r[59:29];
  assign q3 = q2_r[61:31];

  // The Barrett estimate leaves a remainder below three times the modulus.
  always_comb begin
    diff    = p3_r - t_r;
    diff_m1 = diff - 32'(MODULUS);
    diff_m2 = diff - MODULUS_X2;
    if (diff >= MODULUS_X2) begin
      res_nxt = diff_m2[DATA_W-1:0];
    end else if (diff >= 32'(MODULUS)) begin
      res_nxt = diff_m1[DATA_W-1:0];
    end else begin
      res_nxt = diff[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
    end else begin
      ctl1_r <= req_ctl;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= 60'(req_x) * 60'(req_y);
    q2_r   <= 62'(q1) * 62'(BARRETT_MU);
    p2_r   <= prod_r[31:0];
    t_r    <= 32'(q3) * 32'(MODULUS);
    p3_r   <= p2_r;
    res_r  <= res_nxt;
  end

  assign rsp_ctl = ctl4_r;
  assign rsp_r   = res_r;

endmodule

`default_nettype wire

>>> rtl/modular_arithmetic_unit.sv
// Power works through the exponent one bit at a time, up to the highest set bit.
// Divide runs a 30-bit Fermat power and one multiply.
// Each exponent bit is a round trip through the four-stage modular multiplier.
// One transaction at a time: busy is high until the strobe cycle, when the next can be taken.
// Synchronous active-low reset returns to idle and drops the strobe.
`default_nettype none

module modular_arithmetic_unit
  import mau_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        in_op,
  input  wire logic [DATA_W-1:0] in_operand_a,
  input  wire logic [DATA_W-1:0] in_operand_b,
  input  wire logic [EXP_W-1:0]  in_exponent,
  output logic                   out_valid,
  output logic      [DATA_W-1:0] out_result,
  output logic                   out_divisor_zero
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_P_CHECK,
    S_P_MUL,
    S_P_WAIT,
    S_F_ISSUE,
    S_F_WAIT
  } state_t;

  state_t            state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_result_r, out_result_nxt;
  logic              out_dz_r, out_dz_nxt;

  logic [2:0]        op_r, op_nxt;
  logic [DATA_W-1:0] a_r, a_nxt;
  logic [DATA_W-1:0] b_r, b_nxt;
  logic [DATA_W-1:0] sq_r, sq_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [EXP_W-1:0]  e_r, e_nxt;

  mm_ctl_t           mm_req, mm_rsp;
  logic [DATA_W-1:0] mm_x, mm_y, mm_r;

  logic [DATA_W:0]   sum_w;
  logic [DATA_W:0]   sum_red;
  logic [DATA_W:0]   sub_wrap;
  logic [DATA_W-1:0] add_res, sub_res;

  function automatic logic [DATA_W-1:0] reduce_once(input logic [DATA_W-1:0] v);
    reduce_once = (v >= MODULUS) ? v - MODULUS : v;
  endfunction

  mau_modmul u_modmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_ctl (mm_req),
    .req_x   (mm_x),
    .req_y   (mm_y),
    .rsp_ctl (mm_rsp),
    .rsp_r   (mm_r)
  );

  always_comb begin
    sum_w    = {1'b0, a_r} + {1'b0, b_r};
    sum_red  = sum_w - {1'b0, MODULUS};
    add_res  = (sum_w >= {1'b0, MODULUS}) ? sum_red[DATA_W-1:0] : sum_w[DATA_W-1:0];
    sub_wrap = {1'b0, a_r} + {1'b0, MODULUS} - {1'b0, b_r};
    sub_res  = (a_r >= b_r) ? a_r - b_r : sub_wrap[DATA_W-1:0];
  end

  // The square and the accumulate for one exponent bit both read the old
  // base, so they enter the multiplier on consecutive cycles.
  always_comb begin
    mm_req = '0;
    mm_x   = sq_r;
    mm_y   = sq_r;
    case (state_r)
      S_P_CHECK: begin
        mm_req.valid = (e_r != '0);
      end
      S_P_MUL: begin
        mm_req.valid   = 1'b1;
        mm_req.acc_dst = 1'b1;
        mm_x           = acc_r;
      end
      S_F_ISSUE: begin
        mm_req.valid   = 1'b1;
        mm_req.acc_dst = 1'b1;
        mm_x           = a_r;
        mm_y           = acc_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;
    out_dz_nxt     = out_dz_r;
    op_nxt         = op_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    sq_nxt         = sq_r;
    acc_nxt        = acc_r;
    e_nxt          = e_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_op;
          a_nxt     = reduce_once(in_operand_a);
          b_nxt     = reduce_once(in_operand_b);
          e_nxt     = in_exponent;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_r)
          OP_ADD: begin
            out_valid_nxt  = 1'b1;
            out_result_nxt = add_res;
            out_dz_nxt     = 1'b0;
            state_nxt      = S_IDLE;
          end
          OP_SUB: begin
            out_valid_nxt  = 1'b1;
            out_result_nxt = sub_res;
            out_dz_nxt     = 1'b0;
            state_nxt      = S_IDLE;
          end
          OP_MUL: begin
            acc_nxt   = b_r;
            state_nxt = S_F_ISSUE;
          end
          OP_POW: begin
            sq_nxt    = a_r;
            acc_nxt   = DATA_W'(1);
            state_nxt = S_P_CHECK;
          end
          OP_DIV: begin
            if (b_r == '0) begin
              out_valid_nxt  = 1'b1;
              out_result_nxt = '0;
              out_dz_nxt     = 1'b1;
              state_nxt      = S_IDLE;
            end else begin
              sq_nxt    = b_r;
              acc_nxt   = DATA_W'(1);
              e_nxt     = EXP_W'(INV_EXP);
              state_nxt = S_P_CHECK;
            end
          end
          default: begin
            out_valid_nxt  = 1'b1;
            out_result_nxt = '0;
            out_dz_nxt     = 1'b0;
            state_nxt      = S_IDLE;
          end
        endcase
      end
      S_P_CHECK: begin
        if (e_r == '0) begin
          if (op_r == OP_DIV) begin
            state_nxt = S_F_ISSUE;
          end else begin
            out_valid_nxt  = 1'b1;
            out_result_nxt = acc_r;
            out_dz_nxt     = 1'b0;
            state_nxt      = S_IDLE;
          end
        end else begin
          state_nxt = S_P_MUL;
        end
      end
      S_P_MUL: begin
        state_nxt = S_P_WAIT;
      end
      S_P_WAIT: begin
        if (mm_rsp.valid) begin
          if (!mm_rsp.acc_dst) begin
            sq_nxt = mm_r;
          end else begin
            if (e_r[0]) begin
              acc_nxt = mm_r;
            end
            e_nxt     = e_r >> 1;
            state_nxt = S_P_CHECK;
          end
        end
      end
      S_F_ISSUE: begin
        state_nxt = S_F_WAIT;
      end
      S_F_WAIT: begin
        if (mm_rsp.valid) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = mm_r;
          out_dz_nxt     = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      out_result_r <= '0;
      out_dz_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      out_result_r <= out_result_nxt;
      out_dz_r     <= out_dz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    sq_r  <= sq_nxt;
    acc_r <= acc_nxt;
    e_r   <= e_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result       = out_result_r;
  assign out_divisor_zero = out_dz_r;

endmodule

`default_nettype wire

>>> rtl/mau_checker.sv
// Port-level checker for the modular arithmetic unit and its bind.
`default_nettype none
`include "modular_arithmetic_unit_defines.svh"

module mau_checker
  import mau_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire logic [DATA_W-1:0] out_result,
  input wire logic              out_divisor_zero
);

  `MAU_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy did not rise after a transaction was accepted")
  `MAU_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe lasted more than one cycle")
  `MAU_ASSERT_SAME(a_dz_zero, out_valid && out_divisor_zero, out_result == '0, "zero divisor flagged with a nonzero result")
  `MAU_ASSERT_SAME(a_reduced, out_valid, out_result < MODULUS, "result is not reduced below the modulus")
  `MAU_ASSERT_SAME(a_done_strobe, $fell(busy), out_valid, "busy dropped without a result strobe")

endmodule

bind modular_arithmetic_unit mau_checker u_mau_checker (.*);

`default_nettype wire
